// ===== rtl/mt64_pkg.sv =====
// Shared types, constants and helper functions for the MT19937-64 generator.
// No dependencies; the KISS unit, the top level and the testbench refer to it by scoped names.
package mt64_pkg;

    localparam int unsigned WORDS      = 312;
    localparam int unsigned MID_OFFSET = 156;
    localparam int unsigned AW         = 9;

    localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] UPPER_MASK   = 64'hFFFFFFFF80000000;
    localparam logic [63:0] LOWER_MASK   = 64'h000000007FFFFFFF;
    localparam logic [63:0] TEMPER_B     = 64'h5555555555555555;
    localparam logic [63:0] TEMPER_C     = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TEMPER_D     = 64'hFFF7EEE000000000;
    localparam logic [63:0] INIT_MULT    = 64'd6364136223846793005;
    localparam logic [63:0] KEY_MULT     = 64'd3935559000370003845;
    localparam logic [63:0] FINAL_MULT   = 64'd2862933555777941757;
    localparam logic [63:0] INIT_WORD    = 64'd19650218;
    localparam logic [63:0] SEED_RESET   = 64'd5489;
    localparam logic [63:0] TOP_BIT      = 64'h8000000000000000;

    localparam logic [31:0] KISS_Z0     = 32'd362436069;
    localparam logic [31:0] KISS_W0     = 32'd521288629;
    localparam logic [31:0] KISS_JSR0   = 32'd123456789;
    localparam logic [31:0] KISS_JCONG0 = 32'd380116160;

    localparam logic [AW-1:0] LAST_IDX = AW'(WORDS - 1);

    // Controller states: seeding (init run, key run, final run) and draw.
    typedef enum logic [3:0] {
        S_IDLE,
        S_A1,
        S_A2,
        S_ST1,
        S_ST2,
        S_ST3,
        S_WRAP,
        S_FIN,
        S_D1,
        S_D2,
        S_D3,
        S_D4,
        S_OUT
    } t_state;

    // Fold the top two bits into the word, used by every init recurrence.
    function automatic logic [63:0] mix62(input logic [63:0] v);
        mix62 = v ^ {62'd0, v[63:62]};
    endfunction

    // Output tempering of one twisted word.
    function automatic logic [63:0] temper(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ ((x >> 29) & TEMPER_B);
        x = x ^ ((x << 17) & TEMPER_C);
        x = x ^ ((x << 37) & TEMPER_D);
        x = x ^ (x >> 43);
        temper = x;
    endfunction

endpackage

// ===== rtl/mt64_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mt64_ram #(
    parameter int unsigned DEPTH = 312,
    parameter int unsigned WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mt64_mul.sv =====
// Sequential 64x64 multiplier keeping the low 64 bits, one 32x32 product a cycle.
// No dependencies.
module mt64_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_pp;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;

    // Control: a start launches four steps, done pulses with the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: low product, then the two cross terms shifted up by 32.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            case (r_step)
                2'd0: r_pp <= r_a[31:0] * r_b[31:0];
                2'd1: begin
                    r_acc <= r_pp;
                    r_pp  <= r_a[31:0] * r_b[63:32];
                end
                2'd2: begin
                    r_acc <= r_acc + {r_pp[31:0], 32'd0};
                    r_pp  <= r_a[63:32] * r_b[31:0];
                end
                default: r_acc <= r_acc + {r_pp[31:0], 32'd0};
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/mt64_kiss.sv =====
// KISS key generator: one 32-bit output per step, result registered.
// No dependencies beyond mt64_pkg for the start constants.
module mt64_kiss (
    input  logic        i_clk,
    input  logic        i_init,
    input  logic [31:0] i_fold,
    input  logic        i_step,
    output logic [31:0] o_value
);

    logic [31:0] r_z;
    logic [31:0] r_w;
    logic [31:0] r_jsr;
    logic [31:0] r_jcong;
    logic [31:0] r_value;
    logic [31:0] n_z;
    logic [31:0] n_w;
    logic [31:0] n_jsr;
    logic [31:0] n_jcong;
    logic [31:0] n_value;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] mwc;

    // Next state of the four component generators.
    always_comb begin
        n_z     = 32'(32'd36969 * {16'd0, r_z[15:0]}) + {16'd0, r_z[31:16]};
        n_w     = 32'(32'd18000 * {16'd0, r_w[15:0]}) + {16'd0, r_w[31:16]};
        mwc     = {n_z[15:0], 16'd0} + n_w;
        n_jcong = 32'(32'd69069 * r_jcong) + 32'd1234567;
        s1      = r_jsr ^ (r_jsr >> 13);
        s2      = s1 ^ (s1 << 17);
        n_jsr   = s2 ^ (s2 << 5);
        n_value = (mwc ^ n_jcong) + n_jsr;
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_z     <= i_fold ^ mt64_pkg::KISS_Z0;
            r_w     <= i_fold ^ mt64_pkg::KISS_W0;
            r_jsr   <= i_fold ^ mt64_pkg::KISS_JSR0;
            r_jcong <= i_fold ^ mt64_pkg::KISS_JCONG0;
        end else if (i_step) begin
            r_z     <= n_z;
            r_w     <= n_w;
            r_jsr   <= n_jsr;
            r_jcong <= n_jcong;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/mt19937_64_generator_unit.sv =====
// MT19937-64 generator top level: controller, state RAM, multiplier and KISS unit.
// Depends on mt64_pkg, mt64_ram, mt64_mul and mt64_kiss.
//
// Each input beat requests one tempered 64-bit word. A draw reads three words of
// the 312-entry state RAM one after another through its single read port, twists
// and writes back one word. The output register is loaded in state S_OUT, which
// waits while an older result is still untaken; the block then returns to idle,
// where it takes the next request, so only one draw is in work at a time. A reseed
// (requested, or forced on the first request after reset) runs first and
// rebuilds the whole array through the shared 4-step multiplier in an init run,
// a key run and a final run. The seed register is 64 bits, reset to 5489, and
// takes effect at the next reseed. The result stays in the output register until
// taken; a new request may be accepted meanwhile.
module mt19937_64_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] reseed, [7:1] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned AW = mt64_pkg::AW;

    mt64_pkg::t_state r_state;
    mt64_pkg::t_state n_state;

    logic [63:0]   r_seed;
    logic          r_needs;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_cnt;
    logic          r_phase_c;
    logic [63:0]   r_prev;
    logic [63:0]   r_cur;
    logic [31:0]   r_hi;
    logic [63:0]   r_wp;
    logic [63:0]   r_wn;
    logic [63:0]   r_new;
    logic [63:0]   r_out;
    logic          r_out_valid;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    logic          mul_start;
    logic [63:0]   mul_b;
    logic          mul_done;
    logic [63:0]   mul_prod;

    logic          kiss_init;
    logic          kiss_step;
    logic [31:0]   kiss_value;

    logic          s_accept;
    logic [AW-1:0] pos_p;
    logic [AW-1:0] pos_nxt;
    logic [AW-1:0] pos_far;
    logic [63:0]   init_val;
    logic [63:0]   step_val;
    logic [63:0]   mixed;
    logic [63:0]   twisted;
    logic          run_last;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == mt64_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;

    // Draw positions: current, next and the one half an array ahead.
    always_comb begin
        pos_p   = (r_pos >= AW'(mt64_pkg::WORDS)) ? '0 : r_pos;
        pos_nxt = (pos_p == mt64_pkg::LAST_IDX) ? '0 : pos_p + AW'(1);
        pos_far = (pos_p >= AW'(mt64_pkg::MID_OFFSET)) ?
                  pos_p - AW'(mt64_pkg::MID_OFFSET) : pos_p + AW'(mt64_pkg::MID_OFFSET);
    end

    // Recurrence results for the init run, the key and final runs and the twist.
    always_comb begin
        init_val = mul_prod + {{(64-AW){1'b0}}, r_idx};
        if (r_phase_c) begin
            step_val = (r_cur ^ mul_prod) - {{(64-AW){1'b0}}, r_idx};
        end else begin
            step_val = (r_cur ^ mul_prod) + {r_hi, kiss_value} + {{(64-AW){1'b0}}, r_cnt};
        end
        mixed   = (r_wp & mt64_pkg::UPPER_MASK) | (r_wn & mt64_pkg::LOWER_MASK);
        twisted = ram_rdata ^ (mixed >> 1) ^ (mixed[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);
        run_last = r_phase_c ? (r_cnt == AW'(mt64_pkg::WORDS - 2))
                             : (r_cnt == mt64_pkg::LAST_IDX);
    end

    // Next state and the RAM, multiplier and KISS controls.
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = step_val;
        ram_raddr = r_idx;
        mul_start = 1'b0;
        kiss_init = 1'b0;
        kiss_step = 1'b0;
        unique case (r_state)
            mt64_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (r_needs || i_s_tdata[0]) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = mt64_pkg::INIT_WORD;
                        kiss_init = 1'b1;
                        n_state   = mt64_pkg::S_A1;
                    end else begin
                        n_state = mt64_pkg::S_D1;
                    end
                end
            end
            mt64_pkg::S_A1: begin
                mul_start = 1'b1;
                n_state   = mt64_pkg::S_A2;
            end
            mt64_pkg::S_A2: begin
                if (mul_done) begin
                    ram_we    = 1'b1;
                    ram_wdata = init_val;
                    n_state   = (r_idx == mt64_pkg::LAST_IDX) ? mt64_pkg::S_ST1
                                                              : mt64_pkg::S_A1;
                end
            end
            mt64_pkg::S_ST1: begin
                mul_start = 1'b1;
                kiss_step = !r_phase_c;
                n_state   = mt64_pkg::S_ST2;
            end
            mt64_pkg::S_ST2: begin
                kiss_step = !r_phase_c;
                n_state   = mt64_pkg::S_ST3;
            end
            mt64_pkg::S_ST3: begin
                if (mul_done) begin
                    ram_we = 1'b1;
                    if (run_last && r_phase_c) begin
                        n_state = mt64_pkg::S_FIN;
                    end else if (r_idx == mt64_pkg::LAST_IDX) begin
                        n_state = mt64_pkg::S_WRAP;
                    end else begin
                        n_state = mt64_pkg::S_ST1;
                    end
                end
            end
            mt64_pkg::S_WRAP: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_prev;
                n_state   = mt64_pkg::S_ST1;
            end
            mt64_pkg::S_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = mt64_pkg::TOP_BIT;
                n_state   = mt64_pkg::S_D1;
            end
            mt64_pkg::S_D1: begin
                ram_raddr = pos_p;
                n_state   = mt64_pkg::S_D2;
            end
            mt64_pkg::S_D2: begin
                ram_raddr = pos_nxt;
                n_state   = mt64_pkg::S_D3;
            end
            mt64_pkg::S_D3: begin
                ram_raddr = pos_far;
                n_state   = mt64_pkg::S_D4;
            end
            mt64_pkg::S_D4: begin
                ram_we    = 1'b1;
                ram_waddr = pos_p;
                ram_wdata = twisted;
                n_state   = mt64_pkg::S_OUT;
            end
            mt64_pkg::S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = mt64_pkg::S_IDLE;
                end
            end
            default: n_state = mt64_pkg::S_IDLE;
        endcase
    end

    // Multiplier constant follows the run in progress.
    always_comb begin
        if (r_state == mt64_pkg::S_A1) begin
            mul_b = mt64_pkg::INIT_MULT;
        end else if (r_phase_c) begin
            mul_b = mt64_pkg::FINAL_MULT;
        end else begin
            mul_b = mt64_pkg::KEY_MULT;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mt64_pkg::S_IDLE;
            r_seed      <= mt64_pkg::SEED_RESET;
            r_needs     <= 1'b1;
            r_pos       <= AW'(mt64_pkg::WORDS);
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_phase_c   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
            if (r_state == mt64_pkg::S_OUT && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                mt64_pkg::S_IDLE: begin
                    r_idx <= AW'(1);
                end
                mt64_pkg::S_A2: begin
                    if (mul_done) begin
                        if (r_idx == mt64_pkg::LAST_IDX) begin
                            r_idx     <= AW'(1);
                            r_cnt     <= '0;
                            r_phase_c <= 1'b0;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                end
                mt64_pkg::S_ST3: begin
                    if (mul_done) begin
                        if (run_last) begin
                            r_cnt     <= '0;
                            r_phase_c <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + AW'(1);
                        end
                        if (r_idx == mt64_pkg::LAST_IDX) begin
                            r_idx <= AW'(1);
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                end
                mt64_pkg::S_FIN: begin
                    r_pos   <= AW'(mt64_pkg::WORDS);
                    r_needs <= 1'b0;
                end
                mt64_pkg::S_D4: begin
                    r_pos <= pos_p + AW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mt64_pkg::S_IDLE: r_prev <= mt64_pkg::INIT_WORD;
            mt64_pkg::S_A2: begin
                if (mul_done) begin
                    r_prev <= (r_idx == mt64_pkg::LAST_IDX) ? mt64_pkg::INIT_WORD : init_val;
                end
            end
            mt64_pkg::S_ST2: begin
                r_cur <= ram_rdata;
                r_hi  <= kiss_value;
            end
            mt64_pkg::S_ST3: begin
                if (mul_done) begin
                    r_prev <= step_val;
                end
            end
            mt64_pkg::S_D2: r_wp <= ram_rdata;
            mt64_pkg::S_D3: r_wn <= ram_rdata;
            mt64_pkg::S_D4: r_new <= twisted;
            mt64_pkg::S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    r_out <= mt64_pkg::temper(r_new);
                end
            end
            default: begin
            end
        endcase
    end

    mt64_ram #(
        .DEPTH(mt64_pkg::WORDS),
        .WIDTH(64)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    mt64_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (mt64_pkg::mix62(r_prev)),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    mt64_kiss u_kiss (
        .i_clk  (i_clk),
        .i_init (kiss_init),
        .i_fold (r_seed[63:32] ^ r_seed[31:0]),
        .i_step (kiss_step),
        .o_value(kiss_value)
    );

endmodule

// ===== rtl/mt64_checker.sv =====
// Port-level checks for the MT19937-64 generator, bound to its top level.
// Depends only on the top level's ports.
module mt64_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_cfg_ready
);

    // A result beat stays offered until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result beat dropped before it was taken");

    // The block is busy in the cycle after it takes a request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while a previous one is still in work");

    // A new result only appears from work in progress, never from idle.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared without a request in work");

    // An offered result word is fully defined.
    a_data_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !$isunknown(o_m_tdata))
        else $error("result word has unknown bits");

    // The seed register is always writable.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind mt19937_64_generator_unit mt64_checker u_mt64_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_cfg_ready(o_cfg_ready)
);

// ===== sim/tb_mt19937_64_generator_unit.sv =====
// Self-checking testbench for the MT19937-64 word generator.
// Depends on rtl/mt64_pkg.sv and rtl/mt19937_64_generator_unit.sv.
`timescale 1ns / 100ps

module tb_mt19937_64_generator_unit;

    localparam int unsigned N_WORDS      = mt64_pkg::WORDS;
    localparam int unsigned N_MID        = mt64_pkg::MID_OFFSET;
    localparam int unsigned IDLE_LIMIT   = 60000;
    localparam int unsigned SETTLE       = 12;
    localparam int unsigned N_RANDOM     = 1900;
    localparam int unsigned N_PHASES     = 6;

    typedef enum logic {ROW_DRAW, ROW_SEED} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        reseed;
        logic [63:0] seed;
    } t_row;

    typedef struct {
        logic [31:0] z, w, jsr, jcong;
    } t_kiss;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [0] reseed, [7:1] zero
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;        // [63:0] value
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data = '0;

    // Shadow copy of the generator state.
    logic [63:0] twist_mem [N_WORDS];
    logic [63:0] seed_reg;
    int unsigned next_pos;
    bit          unseeded;

    logic [63:0] words_due[$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    bit          stim_done = 1'b0;

    mt19937_64_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // One step of the KISS key source, all arithmetic modulo 2^32.
    function automatic logic [31:0] kiss_step(ref t_kiss k);
        logic [31:0] mwc;
        k.z = 32'd36969 * {16'd0, k.z[15:0]} + (k.z >> 16);
        k.w = 32'd18000 * {16'd0, k.w[15:0]} + (k.w >> 16);
        mwc = (k.z << 16) + k.w;
        k.jcong = 32'd69069 * k.jcong + 32'd1234567;
        k.jsr = k.jsr ^ (k.jsr >> 13);
        k.jsr = k.jsr ^ (k.jsr << 17);
        k.jsr = k.jsr ^ (k.jsr << 5);
        return (mwc ^ k.jcong) + k.jsr;
    endfunction

    function automatic logic [63:0] fold_top(logic [63:0] v);
        return v ^ (v >> 62);
    endfunction

    // Rebuild the whole twister array from the folded seed.
    task automatic rebuild_array();
        t_kiss       k;
        logic [31:0] f;
        logic [63:0] key, hi, lo;
        int unsigned i;
        f = seed_reg[63:32] ^ seed_reg[31:0];
        k.z = f ^ 32'd362436069;
        k.w = f ^ 32'd521288629;
        k.jsr = f ^ 32'd123456789;
        k.jcong = f ^ 32'd380116160;
        twist_mem[0] = 64'd19650218;
        for (int n = 1; n < N_WORDS; n++)
            twist_mem[n] = 64'd6364136223846793005 * fold_top(twist_mem[n-1]) + 64'(n);
        i = 1;
        for (int j = 0; j < N_WORDS; j++) begin
            hi = {32'd0, kiss_step(k)};
            lo = {32'd0, kiss_step(k)};
            key = (hi << 32) | lo;
            twist_mem[i] = (twist_mem[i] ^ (fold_top(twist_mem[i-1]) * 64'd3935559000370003845))
                           + key + 64'(j);
            i++;
            if (i >= N_WORDS) begin
                twist_mem[0] = twist_mem[N_WORDS-1];
                i = 1;
            end
        end
        for (int n = N_WORDS - 1; n > 0; n--) begin
            twist_mem[i] = (twist_mem[i] ^ (fold_top(twist_mem[i-1]) * 64'd2862933555777941757))
                           - 64'(i);
            i++;
            if (i >= N_WORDS) begin
                twist_mem[0] = twist_mem[N_WORDS-1];
                i = 1;
            end
        end
        twist_mem[0] = 64'h8000000000000000;
        next_pos = N_WORDS;
        unseeded = 1'b0;
    endtask

    // Reseed first if needed, then twist one word in place and return its tempered value.
    task automatic draw_word(input logic reseed, output logic [63:0] word);
        int unsigned p, nxt, far;
        logic [63:0] x;
        if (unseeded || reseed)
            rebuild_array();
        p = (next_pos >= N_WORDS) ? 0 : next_pos;
        nxt = (p + 1 < N_WORDS) ? p + 1 : 0;
        far = (p + N_MID) % N_WORDS;
        x = (twist_mem[p] & 64'hFFFFFFFF80000000) | (twist_mem[nxt] & 64'h7FFFFFFF);
        twist_mem[p] = twist_mem[far] ^ (x >> 1) ^ (x[0] ? 64'hB5026F5AA96619E9 : 64'd0);
        x = twist_mem[p];
        x = x ^ ((x >> 29) & 64'h5555555555555555);
        x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
        x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
        x = x ^ (x >> 43);
        next_pos = p + 1;
        word = x;
    endtask

    // Track accepted beats and check every returned word.
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                seed_reg = i_cfg_data;
            if (i_s_tvalid && o_s_tready) begin
                draw_word(i_s_tdata[0], want);
                words_due.push_back(want);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", o_m_tdata);
                end else begin
                    want = words_due.pop_front();
                    if (want !== o_m_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word mismatch: expected %h got %h", want, o_m_tdata);
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: random stall before each beat, held ready until it is taken.
    initial begin
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Request beat with a random gap; valid stays high across back-to-back beats.
    task automatic send_request(input logic reseed, input bit no_gap);
        int unsigned gap;
        @(negedge i_clk);
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, reseed};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    // Seed writes happen only once every outstanding word has come back.
    task automatic write_seed(input logic [63:0] value);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    t_row directed[] = '{
        '{ROW_DRAW, 1'b0, 64'd0},               // unseeded draw forces seeding
        '{ROW_DRAW, 1'b0, 64'd0},
        '{ROW_DRAW, 1'b0, 64'd0},
        '{ROW_DRAW, 1'b1, 64'd0},               // explicit reseed, same seed
        '{ROW_DRAW, 1'b0, 64'd0},
        '{ROW_SEED, 1'b0, 64'd0},
        '{ROW_DRAW, 1'b0, 64'd0},               // write alone does not reseed
        '{ROW_DRAW, 1'b1, 64'd0},
        '{ROW_DRAW, 1'b0, 64'd0},
        '{ROW_SEED, 1'b0, 64'hFFFFFFFFFFFFFFFF},
        '{ROW_DRAW, 1'b1, 64'd0},
        '{ROW_DRAW, 1'b0, 64'd0},
        '{ROW_SEED, 1'b0, 64'h12345678_12345678}, // folds to zero
        '{ROW_DRAW, 1'b1, 64'd0},
        '{ROW_DRAW, 1'b1, 64'd0},
        '{ROW_SEED, 1'b0, 64'h8000000000000001},
        '{ROW_DRAW, 1'b1, 64'd0},
        '{ROW_DRAW, 1'b0, 64'd0}
    };

    initial begin
        logic [63:0] seed_val;
        int unsigned per_phase, reseed_odds;
        seed_reg = 64'd5489;
        next_pos = N_WORDS;
        unseeded = 1'b1;
        for (int n = 0; n < N_WORDS; n++) twist_mem[n] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].kind == ROW_SEED)
                write_seed(directed[r].seed);
            else
                send_request(directed[r].reseed, 1'b0);
        end

        // Random phases; one runs long enough to wrap the read position.
        per_phase = N_RANDOM / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: seed_val = 64'd0;
                1: seed_val = 64'hFFFFFFFFFFFFFFFF;
                2: seed_val = 64'd5489;
                default: seed_val = {$urandom, $urandom};
            endcase
            write_seed(seed_val);
            reseed_odds = (ph == 2) ? 0 : 96;
            for (int n = 0; n < per_phase; n++) begin
                send_request((n == 0) || (reseed_odds != 0 && $urandom_range(1, reseed_odds) == 1),
                             $urandom_range(0, 3) == 0 || (n >= 40 && n < 80));
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
